>>> rtl/ffd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared types and constants for the FF 55 serial frame deframer.
// ----------------------------------------------------------------------------
package ffd_pkg;

   // Sync pattern and slot positions
   localparam logic [7:0] SYNC_FIRST      = 8'hFF;
   localparam logic [7:0] SYNC_SECOND     = 8'h55;
   localparam int         SLOT_AFTER_SYNC = 1;
   localparam int         SLOT_LENGTH     = 2;
   localparam int         SLOT_MIN_DONE   = 3;

   // Remaining count floor
   localparam logic signed [8:0] COUNT_MIN = -9'sd256;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Classified byte as it travels from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       is_sync_first;
      logic       is_sync_second;
   } item_type;

endpackage

>>> rtl/ffd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_front
// Accepts received bytes, tags sync bytes and holds them for the queue.
// ----------------------------------------------------------------------------
module ffd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   output logic              q_valid,
   input  logic              q_ready,
   output ffd_pkg::item_type q_item
);
   import ffd_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     take;

   // Accept while empty or while the held item moves on
   assign req_ready = !valid_ff || q_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (q_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Classify the byte on entry
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data           <= req_rx_byte;
         item_ff.is_sync_first  <= (req_rx_byte == SYNC_FIRST);
         item_ff.is_sync_second <= (req_rx_byte == SYNC_SECOND);
      end
   end

   assign q_valid = valid_ff;
   assign q_item  = item_ff;

endmodule

>>> rtl/ffd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_queue
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module ffd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ffd_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output ffd_pkg::item_type out_item
);
   import ffd_pkg::*;

   item_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   push;
   logic                   pop;

   assign in_ready  = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

>>> rtl/ffd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_back
// Runs the frame state for each queued byte and registers the result item.
// ----------------------------------------------------------------------------
module ffd_back #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  ffd_pkg::item_type q_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_data_byte,
   output logic [5:0]        rsp_store_slot,
   output logic              rsp_frame_open,
   output logic              rsp_frame_done,
   output logic signed [8:0] rsp_bytes_left
);
   import ffd_pkg::*;

   localparam int SLOT_W = $clog2(BUFFER_DEPTH);

   // Frame state
   logic                   started_ff;
   logic                   started_in;
   logic                   prev_ff_ff;
   logic                   prev_ff_in;
   logic [SLOT_W-1:0]      slot_ff;
   logic [SLOT_W-1:0]      slot_in;
   logic signed [8:0]      len_ff;
   logic signed [8:0]      len_in;

   // Working values
   logic                   started_mid;
   logic [SLOT_W-1:0]      cur_slot;
   logic [SLOT_W:0]        slot_inc;
   logic [SLOT_W+5:0]      slot_ext;
   logic                   done;

   // Result register
   logic                   valid_ff;
   logic                   valid_in;
   logic [7:0]             data_ff;
   logic [5:0]             slot_out_ff;
   logic                   open_ff;
   logic                   done_ff;
   logic signed [8:0]      left_ff;
   logic                   pop;

   assign q_ready = !valid_ff || rsp_ready;
   assign pop     = q_valid && q_ready;

   // Compute the next frame state for the byte at the queue head
   always_comb begin
      cur_slot    = slot_ff;
      started_mid = started_ff;
      prev_ff_in  = prev_ff_ff;
      len_in      = len_ff;
      if (q_item.is_sync_second && !started_ff) begin
         // start candidate: keep previous byte, open on a preceding FF
         if (prev_ff_ff) begin
            cur_slot    = SLOT_W'(SLOT_AFTER_SYNC);
            started_mid = 1'b1;
         end
      end else begin
         prev_ff_in = q_item.is_sync_first;
         if (started_ff) begin
            if (slot_ff == SLOT_W'(SLOT_LENGTH)) begin
               len_in = $signed({1'b0, q_item.data});
            end else if (slot_ff > SLOT_W'(SLOT_LENGTH) && len_ff != COUNT_MIN) begin
               len_in = len_ff - 9'sd1;
            end
         end
      end

      slot_inc   = {1'b0, cur_slot} + (SLOT_W + 1)'(1);
      started_in = started_mid;
      done       = 1'b0;
      if (slot_inc >= (SLOT_W + 1)'(BUFFER_DEPTH)) begin
         // wrap the slot and drop any open frame
         slot_in    = '0;
         started_in = 1'b0;
      end else begin
         slot_in = slot_inc[SLOT_W-1:0];
      end
      if (started_in && len_in == 9'sd0 && slot_inc > (SLOT_W + 1)'(SLOT_MIN_DONE)) begin
         started_in = 1'b0;
         done       = 1'b1;
         slot_in    = '0;
      end

      slot_ext = (SLOT_W + 6)'(cur_slot);
   end

   // Commit frame state on each byte taken
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         prev_ff_ff <= 1'b0;
         slot_ff    <= '0;
         len_ff     <= '0;
      end else if (pop) begin
         started_ff <= started_in;
         prev_ff_ff <= prev_ff_in;
         slot_ff    <= slot_in;
         len_ff     <= len_in;
      end
   end

   // Hold the result until it is taken
   always_comb begin
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff     <= q_item.data;
         slot_out_ff <= slot_ext[5:0];
         open_ff     <= started_in;
         done_ff     <= done;
         left_ff     <= len_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_store_slot = slot_out_ff;
   assign rsp_frame_open = open_ff;
   assign rsp_frame_done = done_ff;
   assign rsp_bytes_left = left_ff;

endmodule

>>> rtl/ff55_serial_frame_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ff55_serial_frame_deframer_top
// Finds FF 55 framed packets in a received byte stream, one byte per item.
// ----------------------------------------------------------------------------
// Each received byte yields exactly one result item carrying the byte, its
// buffer slot, the frame open and frame done flags and the remaining length.
// The block takes one byte per clock cycle while neither side stalls; each
// byte passes through the input register, the two-entry queue and the result
// register. The frame state update in the back end is combinational from the
// queue head into the frame state registers, which sets the rate. Either side
// may stall independently; the queue and result register absorb backpressure
// without dropping items. BUFFER_DEPTH (8 to 64) sets the slot wrap point.
// ----------------------------------------------------------------------------
module ff55_serial_frame_deframer_top #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_data_byte,
   output logic [5:0]        rsp_store_slot,
   output logic              rsp_frame_open,
   output logic              rsp_frame_done,
   output logic signed [8:0] rsp_bytes_left
);
   import ffd_pkg::*;

   logic     fr_valid;
   logic     fr_ready;
   item_type fr_item;
   logic     bk_valid;
   logic     bk_ready;
   item_type bk_item;

   // Accept and classify
   ffd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_valid     (fr_valid),
      .q_ready     (fr_ready),
      .q_item      (fr_item)
   );

   // Decouple
   ffd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_item   (fr_item),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_item  (bk_item)
   );

   // Track frames and report
   ffd_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (bk_valid),
      .q_ready        (bk_ready),
      .q_item         (bk_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_store_slot (rsp_store_slot),
      .rsp_frame_open (rsp_frame_open),
      .rsp_frame_done (rsp_frame_done),
      .rsp_bytes_left (rsp_bytes_left)
   );

endmodule

>>> verif/ff55_serial_frame_deframer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ff55_serial_frame_deframer_top_test
// Self-checking bench for the FF 55 serial frame deframer.
// ----------------------------------------------------------------------------
// Feeds a byte stream through the request channel and checks each response
// item against a cycle-free model of the deframer state: previous byte,
// open flag, write slot and remaining count. A short hand-built stream comes
// first: bit extremes, back-to-back frames, sync bytes inside a payload, a
// lone 0x55, and the longest length. Random traffic follows. It is mostly
// well-formed frames with random payloads, including zero-length frames and
// frames longer than the buffer, mixed with noise and broken sync pairs.
// Both channels idle and stall at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module ff55_serial_frame_deframer_top_test;
   import ffd_pkg::*;

   localparam int BUFFER_DEPTH = 64;
   localparam int RANDOM_ITEMS = 850;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;

   // One response item as seen on the result channel
   typedef struct packed {
      logic [7:0]        data_byte;
      logic [5:0]        store_slot;
      logic              frame_open;
      logic              frame_done;
      logic signed [8:0] bytes_left;
   } slot_report_type;

   // Track deframer state and hold the response items still owed
   class frame_tracker;
      logic [7:0]        previous_byte;
      logic              frame_started;
      logic [6:0]        write_slot;
      logic signed [8:0] length_left;
      slot_report_type   owed_reports[$];
      int                mismatches;
      int                results_seen;
      int                frames_opened;
      int                frames_done;
      int                zero_lengths;
      int                slot_wraps;

      function new();
         previous_byte = '0;
         frame_started = 1'b0;
         write_slot    = '0;
         length_left   = '0;
         mismatches    = 0;
         results_seen  = 0;
         frames_opened = 0;
         frames_done   = 0;
         zero_lengths  = 0;
         slot_wraps    = 0;
      endfunction

      // Advance the state by one accepted byte and queue the response it causes
      function void note_byte(logic [7:0] c);
         slot_report_type rep;
         logic [6:0]      slot_now;
         rep.frame_done = 1'b0;
         if (write_slot >= BUFFER_DEPTH) write_slot = '0;

         // A 0x55 outside a frame is a start candidate and leaves previous_byte alone
         if (c == SYNC_SECOND && !frame_started) begin
            if (previous_byte == SYNC_FIRST) begin
               write_slot    = 7'(SLOT_AFTER_SYNC);
               frame_started = 1'b1;
               frames_opened++;
            end
         end else begin
            previous_byte = c;
            if (frame_started) begin
               if (write_slot == SLOT_LENGTH) begin
                  length_left = $signed({1'b0, c});
                  if (c == 8'h00) zero_lengths++;
               end else if (write_slot > SLOT_LENGTH && length_left > COUNT_MIN) begin
                  length_left = length_left - 9'sd1;
               end
            end
         end

         // Store at the current slot, then advance and wrap
         slot_now   = write_slot;
         write_slot = write_slot + 7'd1;
         if (write_slot >= BUFFER_DEPTH) begin
            write_slot    = '0;
            frame_started = 1'b0;
            slot_wraps++;
         end
         if (frame_started && length_left == 0 && write_slot > SLOT_MIN_DONE) begin
            frame_started  = 1'b0;
            rep.frame_done = 1'b1;
            write_slot     = '0;
            frames_done++;
         end

         rep.data_byte  = c;
         rep.store_slot = slot_now[5:0];
         rep.frame_open = frame_started;
         rep.bytes_left = length_left;
         owed_reports.push_back(rep);
      endfunction

      // Compare a response item with the oldest one owed
      function void check_result(slot_report_type got);
         slot_report_type exp;
         results_seen++;
         if (owed_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: unexpected response byte %02h slot %0d",
                        got.data_byte, got.store_slot);
            return;
         end
         exp = owed_reports.pop_front();
         if (got.data_byte !== exp.data_byte || got.store_slot !== exp.store_slot ||
             got.frame_open !== exp.frame_open || got.frame_done !== exp.frame_done ||
             got.bytes_left !== exp.bytes_left) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display({"ERROR: response %0d expected byte %02h slot %0d",
                         " open %0b done %0b left %0d"},
                        results_seen, exp.data_byte, exp.store_slot, exp.frame_open,
                        exp.frame_done, exp.bytes_left);
               $display("       got      byte %02h slot %0d open %0b done %0b left %0d",
                        got.data_byte, got.store_slot, got.frame_open,
                        got.frame_done, got.bytes_left);
            end
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_rx_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [7:0]        rsp_data_byte;
   logic [5:0]        rsp_store_slot;
   logic              rsp_frame_open;
   logic              rsp_frame_done;
   logic signed [8:0] rsp_bytes_left;

   frame_tracker    tracker = new();
   slot_report_type seen_report;
   bit              no_idle = 1'b0;
   int              stall_left = 0;
   int              bytes_sent = 0;
   int              cycle_count = 0;

   // Hand-built opening stream: extremes, back-to-back frames, sync bytes as data
   logic [7:0] opening_bytes[$] = '{
      8'h00, 8'h80, 8'h7F, 8'hFF, 8'h55, 8'h01, 8'hAB,
      8'h55,
      8'hFF, 8'h55, 8'h03, 8'hFF, 8'h55, 8'hFF,
      8'h55, 8'h02, 8'h00, 8'h7F,
      8'hFF, 8'h55, 8'hFF
   };

   ff55_serial_frame_deframer_top #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_byte (rsp_data_byte),
      .rsp_store_slot(rsp_store_slot),
      .rsp_frame_open(rsp_frame_open),
      .rsp_frame_done(rsp_frame_done),
      .rsp_bytes_left(rsp_bytes_left)
   );

   always #4 clock = ~clock;

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Payload byte, biased toward the sync values
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return SYNC_FIRST;
      if (r < 16) return SYNC_SECOND;
      return 8'($urandom_range(0, 255));
   endfunction

   // Offer one byte and hold it until it is taken
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Stall the response channel in bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_ready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // Watch both handshakes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.note_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            seen_report.data_byte  = rsp_data_byte;
            seen_report.store_slot = rsp_store_slot;
            seen_report.frame_open = rsp_frame_open;
            seen_report.frame_done = rsp_frame_done;
            seen_report.bytes_left = rsp_bytes_left;
            tracker.check_result(seen_report);
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles, %0d responses owed",
                  cycle_count, tracker.owed_reports.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int         kind;
      int         len;
      int         count;
      int         target;
      logic [7:0] tail;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

      // Random traffic: mostly frames, some noise and broken sync pairs
      target = bytes_sent + RANDOM_ITEMS;
      while (bytes_sent < target) begin
         no_idle = ($urandom_range(0, 9) == 0);
         kind    = $urandom_range(0, 99);
         if (kind < 70) begin
            count = $urandom_range(0, 99);
            if (count < 6) len = 0;
            else if (count < 14) len = $urandom_range(40, 255);
            else len = $urandom_range(1, 20);
            send_byte(SYNC_FIRST);
            send_byte(SYNC_SECOND);
            send_byte(8'(len));
            // A zero length only ends at the slot wrap, so run past it
            count = (len == 0) ? 62 : ((len > 70) ? 70 : len);
            repeat (count) send_byte(pick_byte());
         end else if (kind < 85) begin
            repeat ($urandom_range(1, 8)) send_byte(pick_byte());
         end else if (kind < 93) begin
            // FF followed by anything but 55
            tail = 8'($urandom_range(0, 254));
            if (tail == SYNC_SECOND) tail = 8'h54;
            send_byte(SYNC_FIRST);
            send_byte(tail);
         end else begin
            send_byte(SYNC_SECOND);
         end
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;

      // Drain the response channel, then watch for stray items
      while (tracker.owed_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes and checked %0d responses, %0d mismatches",
               bytes_sent, tracker.results_seen, tracker.mismatches);
      $display("Frames opened %0d, completed %0d, zero length %0d, slot wraps %0d",
               tracker.frames_opened, tracker.frames_done, tracker.zero_lengths,
               tracker.slot_wraps);
      if (tracker.mismatches == 0 && tracker.owed_reports.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/ffd_pkg.sv
rtl/ffd_front.sv
rtl/ffd_queue.sv
rtl/ffd_back.sv
rtl/ff55_serial_frame_deframer_top.sv
verif/ff55_serial_frame_deframer_top_test.sv
